@@ rtl/dprbg_pkg.sv @@
package dprbg_pkg;

   // Potentiometer geometry
   localparam int POT_STEPS = 64;
   localparam int PULSE_W   = $clog2(POT_STEPS + 1);
   localparam int LEVEL_W   = 6;
   localparam int LEVEL_MAX = (1 << LEVEL_W) - 1;
   localparam logic [LEVEL_W-1:0] START_LEVEL =
      LEVEL_W'((POT_STEPS - 1) > LEVEL_MAX ? LEVEL_MAX : (POT_STEPS - 1));

   // Timing registers
   localparam int STEP_W = 20;
   localparam int WAIT_W = 24;
   localparam logic [STEP_W-1:0] STEP_DELAY_RESET = STEP_W'(10);
   localparam logic [WAIT_W-1:0] SETTLE_RESET     = WAIT_W'(500000);

   // Register map
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic REG_STEP_DELAY = 1'b0;
   localparam logic REG_SETTLE     = 1'b1;

   // Sequencer phases
   localparam int PHASE_W = 4;
   localparam logic [PHASE_W-1:0] PH_IDLE         = 4'd0;
   localparam logic [PHASE_W-1:0] PH_PWR_CHECK    = 4'd1;
   localparam logic [PHASE_W-1:0] PH_PREP_UD_HIGH = 4'd2;
   localparam logic [PHASE_W-1:0] PH_PREP_CS_LOW  = 4'd3;
   localparam logic [PHASE_W-1:0] PH_RST_DOWN     = 4'd4;
   localparam logic [PHASE_W-1:0] PH_RST_UP       = 4'd5;
   localparam logic [PHASE_W-1:0] PH_RST_DESELECT = 4'd6;
   localparam logic [PHASE_W-1:0] PH_SETTLE       = 4'd7;
   localparam logic [PHASE_W-1:0] PH_DUMMY_READ   = 4'd8;
   localparam logic [PHASE_W-1:0] PH_MEAS_UD_LOW  = 4'd9;
   localparam logic [PHASE_W-1:0] PH_MEAS_CS_LOW  = 4'd10;
   localparam logic [PHASE_W-1:0] PH_MEAS_SAMPLE  = 4'd11;
   localparam logic [PHASE_W-1:0] PH_MEAS_DOWN    = 4'd12;
   localparam logic [PHASE_W-1:0] PH_FINISH       = 4'd13;

   typedef struct packed {
      logic               chip_select_n;
      logic               up_down;
      logic               busy_res;
      logic               done_res;
      logic               charging;
      logic [LEVEL_W-1:0] level;
   } dprbg_res_type;

endpackage

@@ rtl/dprbg_seq.sv @@
module dprbg_seq
   import dprbg_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                step_en,
   input  logic                start_req,
   input  logic                comparator_level,
   input  logic                power_pin_level,
   input  logic [STEP_W-1:0]   step_delay,
   input  logic [WAIT_W-1:0]   settle,
   output dprbg_res_type       step_res
);

   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic [WAIT_W-1:0]  wait_ff, wait_in;
   logic [PULSE_W-1:0] pulse_ff, pulse_in;
   logic [LEVEL_W-1:0] level_ff, level_in;
   logic               cs_ff, cs_in;
   logic               ud_ff, ud_in;
   logic               done, chg;
   logic [LEVEL_W-1:0] lvl;

   always_comb begin
      phase_in = phase_ff;
      wait_in  = wait_ff;
      pulse_in = pulse_ff;
      level_in = level_ff;
      cs_in    = cs_ff;
      ud_in    = ud_ff;
      done     = 1'b0;
      chg      = 1'b0;
      lvl      = '0;
      if (phase_ff == PH_IDLE || phase_ff > PH_FINISH) begin
         phase_in = PH_IDLE;
         if (start_req) begin
            phase_in = PH_PWR_CHECK;
            wait_in  = WAIT_W'(step_delay);
            pulse_in = '0;
            level_in = START_LEVEL;
         end
      end else if (wait_ff != '0) begin
         wait_in = wait_ff - 1'b1;
      end else begin
         wait_in = WAIT_W'(step_delay);
         case (phase_ff)
            PH_PWR_CHECK: begin
               if (!power_pin_level) begin
                  done     = 1'b1;
                  chg      = 1'b1;
                  wait_in  = '0;
                  phase_in = PH_IDLE;
               end else begin
                  phase_in = PH_PREP_UD_HIGH;
               end
            end
            PH_PREP_UD_HIGH: begin
               ud_in    = 1'b1;
               phase_in = PH_PREP_CS_LOW;
            end
            PH_PREP_CS_LOW: begin
               cs_in    = 1'b0;
               phase_in = PH_RST_DOWN;
            end
            PH_RST_DOWN: begin
               ud_in    = 1'b0;
               phase_in = PH_RST_UP;
            end
            PH_RST_UP: begin
               ud_in    = 1'b1;
               pulse_in = pulse_ff + 1'b1;
               phase_in = (pulse_in >= PULSE_W'(POT_STEPS)) ? PH_RST_DESELECT : PH_RST_DOWN;
            end
            PH_RST_DESELECT: begin
               cs_in    = 1'b1;
               phase_in = PH_SETTLE;
            end
            PH_SETTLE: begin
               wait_in  = settle;
               phase_in = PH_DUMMY_READ;
            end
            PH_DUMMY_READ: begin
               phase_in = PH_MEAS_UD_LOW;
            end
            PH_MEAS_UD_LOW: begin
               ud_in    = 1'b0;
               phase_in = PH_MEAS_CS_LOW;
            end
            PH_MEAS_CS_LOW: begin
               cs_in    = 1'b0;
               phase_in = PH_MEAS_SAMPLE;
            end
            PH_MEAS_SAMPLE: begin
               if (comparator_level && level_ff != '0) begin
                  ud_in    = 1'b1;
                  phase_in = PH_MEAS_DOWN;
               end else begin
                  cs_in    = 1'b1;
                  phase_in = PH_FINISH;
               end
            end
            PH_MEAS_DOWN: begin
               ud_in = 1'b0;
               if (level_ff != '0) begin
                  level_in = level_ff - 1'b1;
               end
               phase_in = PH_MEAS_SAMPLE;
            end
            default: begin
               // finish: report the count
               done     = 1'b1;
               lvl      = level_ff;
               wait_in  = '0;
               phase_in = PH_IDLE;
            end
         endcase
      end
   end

   always_comb begin
      step_res.chip_select_n = cs_in;
      step_res.up_down       = ud_in;
      step_res.busy_res      = (phase_in != PH_IDLE);
      step_res.done_res      = done;
      step_res.charging      = chg;
      step_res.level         = lvl;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         wait_ff  <= '0;
         pulse_ff <= '0;
         level_ff <= START_LEVEL;
         cs_ff    <= 1'b1;
         ud_ff    <= 1'b0;
      end else if (step_en) begin
         phase_ff <= phase_in;
         wait_ff  <= wait_in;
         pulse_ff <= pulse_in;
         level_ff <= level_in;
         cs_ff    <= cs_in;
         ud_ff    <= ud_in;
      end
   end

   a_done_ends_run: assert property (@(posedge clock) disable iff (reset)
      step_res.done_res |-> !step_res.busy_res)
      else $error("result reported while sequence still running");

   a_level_only_with_done: assert property (@(posedge clock) disable iff (reset)
      (step_res.level != '0) |-> (step_res.done_res && !step_res.charging))
      else $error("level driven outside a battery result");

   a_phase_legal: assert property (@(posedge clock) disable iff (reset)
      phase_ff <= PH_FINISH)
      else $error("phase left the legal range");

   a_pulse_bound: assert property (@(posedge clock) disable iff (reset)
      pulse_ff <= PULSE_W'(POT_STEPS))
      else $error("reset pulse count overran");

endmodule

@@ rtl/dprbg_out_buf.sv @@
module dprbg_out_buf
   import dprbg_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  dprbg_res_type push_res,
   output logic          space,
   output logic          out_valid,
   input  logic          out_ready,
   output dprbg_res_type out_res
);

   logic          main_valid_ff, skid_valid_ff;
   dprbg_res_type main_ff, skid_ff;
   logic          pop;

   assign pop       = main_valid_ff && out_ready;
   assign space     = !skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_res   = main_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (pop) begin
         if (skid_valid_ff) begin
            skid_valid_ff <= 1'b0;
         end else begin
            main_valid_ff <= push;
         end
      end else if (push) begin
         if (main_valid_ff) begin
            skid_valid_ff <= 1'b1;
         end else begin
            main_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop && skid_valid_ff) begin
         main_ff <= skid_ff;
      end else if (push && (pop || !main_valid_ff)) begin
         main_ff <= push_res;
      end
      if (push && main_valid_ff && !pop) begin
         skid_ff <= push_res;
      end
   end

   a_skid_behind_main: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> main_valid_ff)
      else $error("skid entry held with empty output stage");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !skid_valid_ff)
      else $error("transfer taken with no room");

endmodule

@@ rtl/digipot_ramp_battery_gauge_top.sv @@
// Channel   Ports                          Direction  Transfer
// ------    -----------------------------  ---------  ---------------------------------
// req       req_valid/req_ready + 3 pins   in         one sampling tick per transfer
// rsp       rsp_valid/rsp_ready + 6 fields out        one result per accepted tick
// csr       csr_psel/penable/pwrite/...    in/out     APB write on access phase
//
// Each tick is processed in the cycle it is accepted: one per clock while req_ready is high.
// The sequencer step is a single pass of logic between its state registers and the output
// stage; a two-entry output buffer (output register plus skid) sets the stall behaviour.
// With rsp_ready held low the block takes up to two more ticks, then drops req_ready.
// Synchronous active-high reset: phase idle, pot deselected, delay registers to defaults.
module digipot_ramp_battery_gauge_top
   import dprbg_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // tick input
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_start_req,
   input  logic                   req_comparator_level,
   input  logic                   req_power_pin_level,
   // result output
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_chip_select_n,
   output logic                   rsp_up_down,
   output logic                   rsp_busy_res,
   output logic                   rsp_done_res,
   output logic                   rsp_charging,
   output logic [LEVEL_W-1:0]     rsp_level,
   // register port
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [CSR_DATA_W-1:0]  csr_pwdata,
   output logic [CSR_DATA_W-1:0]  csr_prdata,
   output logic                   csr_pready
);

   logic [STEP_W-1:0] step_delay_ff;
   logic [WAIT_W-1:0] settle_ff;
   logic              csr_wr;
   logic              req_xfer;
   dprbg_res_type     step_res;
   dprbg_res_type     out_res;

   // Registers are word aligned: decode on the word index, ignore the byte offset
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_delay_ff <= STEP_DELAY_RESET;
         settle_ff     <= SETTLE_RESET;
      end else if (csr_wr) begin
         if (csr_paddr[2] == REG_STEP_DELAY) begin
            step_delay_ff <= csr_pwdata[STEP_W-1:0];
         end else begin
            settle_ff <= csr_pwdata[WAIT_W-1:0];
         end
      end
   end

   always_comb begin
      if (csr_paddr[2] == REG_SETTLE) begin
         csr_prdata = CSR_DATA_W'(settle_ff);
      end else begin
         csr_prdata = CSR_DATA_W'(step_delay_ff);
      end
   end

   // Advance the sequencer once per accepted tick
   assign req_xfer = req_valid && req_ready;

   dprbg_seq u_seq (
      .clock            (clock),
      .reset            (reset),
      .step_en          (req_xfer),
      .start_req        (req_start_req),
      .comparator_level (req_comparator_level),
      .power_pin_level  (req_power_pin_level),
      .step_delay       (step_delay_ff),
      .settle           (settle_ff),
      .step_res         (step_res)
   );

   // Hold results until the consumer takes them
   dprbg_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (req_xfer),
      .push_res  (step_res),
      .space     (req_ready),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_res   (out_res)
   );

   assign rsp_chip_select_n = out_res.chip_select_n;
   assign rsp_up_down       = out_res.up_down;
   assign rsp_busy_res      = out_res.busy_res;
   assign rsp_done_res      = out_res.done_res;
   assign rsp_charging      = out_res.charging;
   assign rsp_level         = out_res.level;

endmodule
